/* hw/rtl/adjoint_window_difference_sum_top_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the adjoint window difference sum block
// Concurrent checks clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef ADJOINT_WINDOW_DIFFERENCE_SUM_TOP_DEFINES_SVH
`define ADJOINT_WINDOW_DIFFERENCE_SUM_TOP_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define AWDS_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent must hold in the cycle after the antecedent
`define AWDS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/awds_pkg.sv */
// ----------------------------------------------------------------------------
// awds_pkg
// Types, codes and constants shared by the window difference sum block.
// ----------------------------------------------------------------------------
package awds_pkg;

	localparam int MAX_WIDTH_DEF  = 32;
	localparam int MAX_HEIGHT_DEF = 32;
	localparam int MAX_HALF_DEF   = 2;

	localparam int VALUE_BITS = 16;
	localparam int SUM_W      = 22;
	localparam int OFF_W      = 3;
	localparam int COORD_W    = 5;
	localparam int SIZE_W     = 6;
	localparam int HALF_W     = 2;

	localparam logic [SIZE_W-1:0] IMG_WIDTH_RST  = 6'd32;
	localparam logic [SIZE_W-1:0] IMG_HEIGHT_RST = 6'd32;
	localparam logic [HALF_W-1:0] HALF_W_RST     = 2'd1;
	localparam logic [HALF_W-1:0] HALF_H_RST     = 2'd1;

	typedef enum logic {
		OP_WRITE = 1'b0,
		OP_QUERY = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		REG_IMG_WIDTH  = 2'd0,
		REG_IMG_HEIGHT = 2'd1,
		REG_HALF_W     = 2'd2,
		REG_HALF_H     = 2'd3
	} reg_idx_t;

	typedef struct packed {
		op_t                           operation;
		logic [COORD_W-1:0]            col;
		logic [COORD_W-1:0]            row;
		logic [OFF_W-1:0]              off_x;
		logic [OFF_W-1:0]              off_y;
		logic signed [VALUE_BITS-1:0]  value;
	} in_item_t;

	typedef struct packed {
		logic signed [SUM_W-1:0] sum;
		logic                    bad_coord;
	} out_item_t;

	typedef struct packed {
		logic [SIZE_W-1:0] img_width;
		logic [SIZE_W-1:0] img_height;
		logic [HALF_W-1:0] half_w;
		logic [HALF_W-1:0] half_h;
	} cfg_t;

	// controller to datapath
	typedef struct packed {
		logic             wr_en;
		logic             start;
		logic             rd_en;
		logic             rd_center;
		logic [OFF_W-1:0] cx;
		logic [OFF_W-1:0] cy;
		logic             finish;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic              in_bad;
		logic [HALF_W-1:0] hw_eff;
		logic [HALF_W-1:0] hh_eff;
		logic              out_free;
	} sts_t;

endpackage

/* hw/rtl/adjoint_window_difference_sum_top.sv */
// ----------------------------------------------------------------------------
// adjoint_window_difference_sum_top
// Windowed difference sum over a stored per-pixel, per-offset field.
// ----------------------------------------------------------------------------
// A write item stores one Q2.14 value, unless its pixel or window index lies
// outside the configured image and window. A query item reads the field store
// through its single port, one read a cycle, two per window offset, then drains
// the read register and loads the output register once the output is free. A
// query outside the image skips the reads and returns a zero sum with bad_coord
// set. The store has no reset; every entry a query touches must have been
// written first. Registers sit on the APB port at 0x0 img_width, 0x4
// img_height, 0x8 half_w, 0xC half_h.
// ----------------------------------------------------------------------------
`include "adjoint_window_difference_sum_top_defines.svh"

module adjoint_window_difference_sum_top #(
	parameter int MAX_WIDTH  = awds_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = awds_pkg::MAX_HEIGHT_DEF,
	parameter int MAX_HALF   = awds_pkg::MAX_HALF_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  awds_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output awds_pkg::out_item_t out_data,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [3:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);

	awds_pkg::cfg_t     cfg_q;
	awds_pkg::cmd_t     cmd;
	awds_pkg::sts_t     sts;
	awds_pkg::reg_idx_t reg_idx;
	logic               cfg_wr;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign reg_idx = awds_pkg::reg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.img_width  <= awds_pkg::IMG_WIDTH_RST;
			cfg_q.img_height <= awds_pkg::IMG_HEIGHT_RST;
			cfg_q.half_w     <= awds_pkg::HALF_W_RST;
			cfg_q.half_h     <= awds_pkg::HALF_H_RST;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				awds_pkg::REG_IMG_WIDTH:  cfg_q.img_width  <= pwdata[awds_pkg::SIZE_W-1:0];
				awds_pkg::REG_IMG_HEIGHT: cfg_q.img_height <= pwdata[awds_pkg::SIZE_W-1:0];
				awds_pkg::REG_HALF_W:     cfg_q.half_w     <= pwdata[awds_pkg::HALF_W-1:0];
				awds_pkg::REG_HALF_H:     cfg_q.half_h     <= pwdata[awds_pkg::HALF_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			awds_pkg::REG_IMG_WIDTH:  prdata = 32'(cfg_q.img_width);
			awds_pkg::REG_IMG_HEIGHT: prdata = 32'(cfg_q.img_height);
			awds_pkg::REG_HALF_W:     prdata = 32'(cfg_q.half_w);
			awds_pkg::REG_HALF_H:     prdata = 32'(cfg_q.half_h);
			default:                  prdata = '0;
		endcase
	end

	awds_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_op    (in_data.operation),
		.sts      (sts),
		.cmd      (cmd)
	);

	awds_dp #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT),
		.MAX_HALF   (MAX_HALF)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cfg       (cfg_q),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	// a query keeps the input closed until its result is loaded into the output register
	`AWDS_ASSERT_NEXT(a_query_busy, in_valid && in_ready && (in_data.operation == awds_pkg::OP_QUERY), !in_ready, "input open during query")
	`AWDS_ASSERT_NEXT(a_finish_out, cmd.finish, out_valid, "result not presented")
	`AWDS_ASSERT_SAME(a_start_acc, cmd.start || cmd.wr_en, in_valid && in_ready, "command without accepted item")
	`AWDS_ASSERT_SAME(a_bad_zero, out_valid && out_data.bad_coord, out_data.sum == '0, "bad pixel with non-zero sum")

endmodule

/* hw/rtl/awds_dp.sv */
// ----------------------------------------------------------------------------
// awds_dp
// Field store, address generation, accumulator and output register.
// ----------------------------------------------------------------------------
module awds_dp #(
	parameter int MAX_WIDTH  = awds_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = awds_pkg::MAX_HEIGHT_DEF,
	parameter int MAX_HALF   = awds_pkg::MAX_HALF_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  awds_pkg::in_item_t  in_data,
	input  awds_pkg::cfg_t      cfg,
	input  awds_pkg::cmd_t      cmd,
	output awds_pkg::sts_t      sts,
	output logic                out_valid,
	input  logic                out_ready,
	output awds_pkg::out_item_t out_data
);

	localparam int WIN    = 2 * MAX_HALF + 1;
	localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT * WIN * WIN;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int ACC_A  = awds_pkg::VALUE_BITS + $clog2(2 * WIN * WIN + 1) + 1;
	localparam int ACC_W  = (ACC_A > awds_pkg::SUM_W) ? ACC_A : awds_pkg::SUM_W + 1;
	localparam int SW     = awds_pkg::SIZE_W;
	localparam int VB     = awds_pkg::VALUE_BITS;
	localparam int OW     = awds_pkg::OFF_W;
	localparam int CW     = awds_pkg::COORD_W;

	localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'((2 ** (awds_pkg::SUM_W - 1)) - 1);
	localparam logic signed [ACC_W-1:0] SAT_LO = -ACC_W'(2 ** (awds_pkg::SUM_W - 1));

	function automatic logic [ADDR_W-1:0] calc_addr(
		input logic [SW-1:0] c,
		input logic [SW-1:0] r,
		input logic [OW-1:0] ox,
		input logic [OW-1:0] oy
	);
		logic [ADDR_W-1:0] pix;
		pix = ADDR_W'(r) * ADDR_W'(MAX_WIDTH) + ADDR_W'(c);
		return (pix * ADDR_W'(WIN) + ADDR_W'(oy)) * ADDR_W'(WIN) + ADDR_W'(ox);
	endfunction

	logic signed [VB-1:0]    mem [DEPTH];
	logic signed [VB-1:0]    rdata_s1;
	logic                    rd_valid_s1;
	logic                    rd_neg_s1;
	logic [CW-1:0]           qcol_q;
	logic [CW-1:0]           qrow_q;
	logic                    bad_q;
	logic signed [ACC_W-1:0] acc_q;
	logic                    out_valid_q;
	awds_pkg::out_item_t     out_q;

	logic [SW-1:0]           w_eff;
	logic [SW-1:0]           h_eff;
	logic [1:0]              hw_eff;
	logic [1:0]              hh_eff;
	logic                    wr_ok;
	logic signed [7:0]       nc;
	logic signed [7:0]       nr;
	logic [SW-1:0]           rd_c;
	logic [SW-1:0]           rd_r;
	logic [ADDR_W-1:0]       waddr;
	logic [ADDR_W-1:0]       raddr;
	logic [ADDR_W-1:0]       mem_addr;
	logic                    mem_we;
	logic signed [ACC_W-1:0] term;
	logic signed [ACC_W-1:0] acc_sat;

	// size registers of zero act as one, oversize ones as the maximum; half sizes clip to MAX_HALF
	always_comb begin
		if (cfg.img_width == '0)
			w_eff = SW'(1);
		else if (11'(cfg.img_width) > 11'(MAX_WIDTH))
			w_eff = SW'(MAX_WIDTH);
		else
			w_eff = cfg.img_width;
		if (cfg.img_height == '0)
			h_eff = SW'(1);
		else if (11'(cfg.img_height) > 11'(MAX_HEIGHT))
			h_eff = SW'(MAX_HEIGHT);
		else
			h_eff = cfg.img_height;
		hw_eff = ({1'b0, cfg.half_w} > 3'(MAX_HALF)) ? 2'(MAX_HALF) : cfg.half_w;
		hh_eff = ({1'b0, cfg.half_h} > 3'(MAX_HALF)) ? 2'(MAX_HALF) : cfg.half_h;
	end

	assign sts.in_bad   = !(({1'b0, in_data.col} < w_eff) && ({1'b0, in_data.row} < h_eff));
	assign sts.hw_eff   = hw_eff;
	assign sts.hh_eff   = hh_eff;
	assign sts.out_free = !out_valid_q || out_ready;

	assign wr_ok = !sts.in_bad && (in_data.off_x <= {hw_eff, 1'b0})
		&& (in_data.off_y <= {hh_eff, 1'b0});

	// neighbour pixel (i - x, j - y), clamped to the image edges
	always_comb begin
		nc = $signed({3'b000, qcol_q}) + $signed({6'b0, hw_eff}) - $signed({5'b0, cmd.cx});
		nr = $signed({3'b000, qrow_q}) + $signed({6'b0, hh_eff}) - $signed({5'b0, cmd.cy});
		if (nc < 0)
			nc = '0;
		else if (nc > $signed({2'b00, w_eff}) - 8'sd1)
			nc = $signed({2'b00, w_eff}) - 8'sd1;
		if (nr < 0)
			nr = '0;
		else if (nr > $signed({2'b00, h_eff}) - 8'sd1)
			nr = $signed({2'b00, h_eff}) - 8'sd1;
		if (cmd.rd_center) begin
			rd_c = {1'b0, qcol_q};
			rd_r = {1'b0, qrow_q};
		end else begin
			rd_c = nc[SW-1:0];
			rd_r = nr[SW-1:0];
		end
	end

	assign waddr    = calc_addr({1'b0, in_data.col}, {1'b0, in_data.row},
		in_data.off_x, in_data.off_y);
	assign raddr    = calc_addr(rd_c, rd_r, cmd.cx, cmd.cy);
	assign mem_we   = cmd.wr_en && wr_ok;
	assign mem_addr = cmd.wr_en ? waddr : raddr;

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_addr] <= in_data.value;
		else if (cmd.rd_en)
			rdata_s1 <= mem[mem_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_valid_s1 <= 1'b0;
			rd_neg_s1   <= 1'b0;
		end else begin
			rd_valid_s1 <= cmd.rd_en;
			rd_neg_s1   <= cmd.rd_center;
		end
	end

	assign term = rd_neg_s1 ? -ACC_W'(rdata_s1) : ACC_W'(rdata_s1);

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			qcol_q <= in_data.col;
			qrow_q <= in_data.row;
			bad_q  <= sts.in_bad;
			acc_q  <= '0;
		end else if (rd_valid_s1) begin
			acc_q <= acc_q + term;
		end
	end

	always_comb begin
		if (acc_q > SAT_HI)
			acc_sat = SAT_HI;
		else if (acc_q < SAT_LO)
			acc_sat = SAT_LO;
		else
			acc_sat = acc_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.finish)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			out_q.sum       <= bad_q ? '0 : acc_sat[awds_pkg::SUM_W-1:0];
			out_q.bad_coord <= bad_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

/* hw/rtl/awds_ctrl.sv */
// ----------------------------------------------------------------------------
// awds_ctrl
// Sequencer: takes items, walks the window offsets of a query, hands over.
// ----------------------------------------------------------------------------
module awds_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  awds_pkg::op_t  in_op,
	input  awds_pkg::sts_t sts,
	output awds_pkg::cmd_t cmd
);

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_RUN   = 4'b0010,
		S_DRAIN = 4'b0100,
		S_DONE  = 4'b1000
	} state_t;

	localparam int OW = awds_pkg::OFF_W;

	state_t        state_q;
	state_t        state_d;
	logic [OW-1:0] cx_q;
	logic [OW-1:0] cy_q;
	logic          ph_q;
	logic          accept;
	logic          last_x;
	logic          last_y;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;
	assign last_x   = (cx_q == {sts.hw_eff, 1'b0});
	assign last_y   = (cy_q == {sts.hh_eff, 1'b0});

	always_comb begin
		cmd.wr_en     = accept && (in_op == awds_pkg::OP_WRITE);
		cmd.start     = accept && (in_op == awds_pkg::OP_QUERY);
		cmd.rd_en     = (state_q == S_RUN);
		cmd.rd_center = ph_q;
		cmd.cx        = cx_q;
		cmd.cy        = cy_q;
		cmd.finish    = (state_q == S_DONE) && sts.out_free;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (cmd.start)
					state_d = sts.in_bad ? S_DONE : S_RUN;
			end
			S_RUN: begin
				if (ph_q && last_x && last_y)
					state_d = S_DRAIN;
			end
			S_DRAIN: state_d = S_DONE;
			S_DONE: begin
				if (sts.out_free)
					state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// each offset takes two reads: neighbour first, then centre
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cx_q    <= '0;
			cy_q    <= '0;
			ph_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.start) begin
				cx_q <= '0;
				cy_q <= '0;
				ph_q <= 1'b0;
			end else if (state_q == S_RUN) begin
				ph_q <= !ph_q;
				if (ph_q) begin
					if (last_x) begin
						cx_q <= '0;
						cy_q <= cy_q + OW'(1);
					end else begin
						cx_q <= cx_q + OW'(1);
					end
				end
			end
		end
	end

endmodule

/* test/adjoint_window_difference_sum_top_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// adjoint_window_difference_sum_top_tb
// Self-checking bench for the window difference sum block. Field writes and
// pixel queries go in over valid/ready, geometry goes in over APB. A local
// copy of the field store and geometry predicts every query sum. Each query's
// footprint is written before the query is sent, so no unwritten entry is read.
// ----------------------------------------------------------------------------
module adjoint_window_difference_sum_top_tb;

	localparam int WIN_DIM       = 2 * awds_pkg::MAX_HALF_DEF + 1;
	localparam int STORE_DEPTH   = awds_pkg::MAX_WIDTH_DEF * awds_pkg::MAX_HEIGHT_DEF
		* WIN_DIM * WIN_DIM;
	localparam int SETTLE_CYCLES = 60;
	localparam int RANDOM_ITEMS  = 850;
	localparam int PHASE_ITEMS   = 90;
	localparam int CW            = awds_pkg::COORD_W;
	localparam int OW            = awds_pkg::OFF_W;
	localparam int VB            = awds_pkg::VALUE_BITS;
	localparam int SW            = awds_pkg::SIZE_W;
	localparam int HB            = awds_pkg::HALF_W;
	localparam int SUM_W         = awds_pkg::SUM_W;
	localparam longint SUM_HI    = (longint'(1) << (SUM_W - 1)) - 1;
	localparam longint SUM_LO    = -(longint'(1) << (SUM_W - 1));

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_ready;
	awds_pkg::in_item_t  in_data;
	logic                out_valid;
	logic                out_ready;
	awds_pkg::out_item_t out_data;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [3:0]          paddr;
	logic [31:0]         pwdata;
	logic [31:0]         prdata;
	logic                pready;

	// local copy of the field store and geometry
	logic signed [VB-1:0] field_img [STORE_DEPTH];
	bit                   field_known [STORE_DEPTH];
	awds_pkg::cfg_t       cfg_regs;
	int                   img_w;
	int                   img_h;
	int                   win_hw;
	int                   win_hh;

	awds_pkg::out_item_t sum_q [$];
	awds_pkg::out_item_t want;
	int                  fails;
	int                  counted_items;
	bit                  send_idle;
	bit                  recv_idle;

	adjoint_window_difference_sum_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("TEST FAILED");
		$finish;
	end

	function automatic int edge_clamp(int v, int n);
		if (v < 0)
			return 0;
		return (v > n - 1) ? n - 1 : v;
	endfunction

	function automatic int slot(int c, int r, int ox, int oy);
		return ((r * awds_pkg::MAX_WIDTH_DEF + c) * WIN_DIM + oy) * WIN_DIM + ox;
	endfunction

	// zero size acts as one, oversize and overlong half sizes are clipped
	function automatic void update_geometry();
		img_w  = (cfg_regs.img_width == '0) ? 1 :
			((int'(cfg_regs.img_width) > awds_pkg::MAX_WIDTH_DEF) ?
			awds_pkg::MAX_WIDTH_DEF : int'(cfg_regs.img_width));
		img_h  = (cfg_regs.img_height == '0) ? 1 :
			((int'(cfg_regs.img_height) > awds_pkg::MAX_HEIGHT_DEF) ?
			awds_pkg::MAX_HEIGHT_DEF : int'(cfg_regs.img_height));
		win_hw = (int'(cfg_regs.half_w) > awds_pkg::MAX_HALF_DEF) ?
			awds_pkg::MAX_HALF_DEF : int'(cfg_regs.half_w);
		win_hh = (int'(cfg_regs.half_h) > awds_pkg::MAX_HALF_DEF) ?
			awds_pkg::MAX_HALF_DEF : int'(cfg_regs.half_h);
	endfunction

	function automatic awds_pkg::out_item_t window_diff_sum(int c, int r);
		awds_pkg::out_item_t res;
		longint              acc;
		int                  x;
		int                  y;
		int                  nc;
		int                  nr;
		res.sum       = '0;
		res.bad_coord = 1'b1;
		if (c >= img_w || r >= img_h)
			return res;
		acc = 0;
		for (y = -win_hh; y <= win_hh; y++) begin
			nr = edge_clamp(r - y, img_h);
			for (x = -win_hw; x <= win_hw; x++) begin
				nc = edge_clamp(c - x, img_w);
				acc += field_img[slot(nc, nr, x + win_hw, y + win_hh)];
				acc -= field_img[slot(c, r, x + win_hw, y + win_hh)];
			end
		end
		if (acc > SUM_HI)
			acc = SUM_HI;
		if (acc < SUM_LO)
			acc = SUM_LO;
		res.sum       = acc[SUM_W-1:0];
		res.bad_coord = 1'b0;
		return res;
	endfunction

	function automatic void apply_item(awds_pkg::in_item_t it);
		int s;
		if (it.operation == awds_pkg::OP_WRITE) begin
			if (int'(it.col) < img_w && int'(it.row) < img_h &&
					int'(it.off_x) <= 2 * win_hw && int'(it.off_y) <= 2 * win_hh) begin
				s = slot(int'(it.col), int'(it.row), int'(it.off_x), int'(it.off_y));
				field_img[s]   = it.value;
				field_known[s] = 1'b1;
			end
		end else begin
			sum_q.push_back(window_diff_sum(int'(it.col), int'(it.row)));
		end
	endfunction

	function automatic awds_pkg::in_item_t make_item(awds_pkg::op_t op, int c, int r,
			int ox, int oy, int v);
		awds_pkg::in_item_t it;
		it.operation = op;
		it.col       = CW'(c);
		it.row       = CW'(r);
		it.off_x     = OW'(ox);
		it.off_y     = OW'(oy);
		it.value     = VB'(v);
		return it;
	endfunction

	task automatic send_item(input awds_pkg::in_item_t it);
		int gap;
		gap = send_idle ? int'($urandom_range(0, 15)) : 0;
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= it;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		apply_item(it);
		counted_items++;
	endtask

	task automatic hold_for_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sum_q.size() != 0) @(posedge clk);
	endtask

	// writes cause no result, so give the block its longest query time as well
	task automatic wait_drained();
		hold_for_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic reg_write(input awds_pkg::reg_idx_t idx, input int val);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		case (idx)
			awds_pkg::REG_IMG_WIDTH:  cfg_regs.img_width  = SW'(val);
			awds_pkg::REG_IMG_HEIGHT: cfg_regs.img_height = SW'(val);
			awds_pkg::REG_HALF_W:     cfg_regs.half_w     = HB'(val);
			awds_pkg::REG_HALF_H:     cfg_regs.half_h     = HB'(val);
			default: ;
		endcase
		update_geometry();
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_geometry(input int w, input int h, input int hw, input int hh);
		wait_drained();
		reg_write(awds_pkg::REG_IMG_WIDTH, w);
		reg_write(awds_pkg::REG_IMG_HEIGHT, h);
		reg_write(awds_pkg::REG_HALF_W, hw);
		reg_write(awds_pkg::REG_HALF_H, hh);
	endtask

	task automatic ensure_written(input int c, input int r, input int ox, input int oy,
			input bit extreme);
		int v;
		if (!field_known[slot(c, r, ox, oy)]) begin
			v = extreme ? (($urandom_range(0, 1) != 0) ? 32767 : -32768) : int'($urandom);
			send_item(make_item(awds_pkg::OP_WRITE, c, r, ox, oy, v));
		end
	endtask

	// fill whatever the query footprint still lacks, then query with junk offsets
	task automatic query_pixel(input int c, input int r, input bit extreme);
		int x;
		int y;
		if (c < img_w && r < img_h) begin
			for (y = -win_hh; y <= win_hh; y++) begin
				for (x = -win_hw; x <= win_hw; x++) begin
					ensure_written(edge_clamp(c - x, img_w), edge_clamp(r - y, img_h),
						x + win_hw, y + win_hh, extreme);
					ensure_written(c, r, x + win_hw, y + win_hh, extreme);
				end
			end
		end
		send_item(make_item(awds_pkg::OP_QUERY, c, r, int'($urandom_range(0, 7)),
			int'($urandom_range(0, 7)), int'($urandom)));
	endtask

	// result sink with random back-pressure
	initial begin : result_sink
		int stall;
		out_ready = 1'b0;
		forever begin
			stall = recv_idle ? int'($urandom_range(0, 15)) : 0;
			@(negedge clk);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (sum_q.size() == 0) begin
				$display("%0t: unexpected item: expected none, actual sum %0d bad_coord %0b",
					$time, out_data.sum, out_data.bad_coord);
				fails++;
			end else begin
				want = sum_q.pop_front();
				if (out_data.sum !== want.sum) begin
					$display("%0t: sum mismatch: expected %0d actual %0d",
						$time, want.sum, out_data.sum);
					fails++;
				end
				if (out_data.bad_coord !== want.bad_coord) begin
					$display("%0t: bad_coord mismatch: expected %0b actual %0b",
						$time, want.bad_coord, out_data.bad_coord);
					fails++;
				end
			end
		end
	end

	// reset geometry, full-scale values, window clamped at the far corner
	task automatic test_reset_window();
		query_pixel(awds_pkg::MAX_WIDTH_DEF - 1, awds_pkg::MAX_HEIGHT_DEF - 1, 1'b1);
	endtask

	// zero width, oversize height, half sizes above the limit
	task automatic test_range_limits();
		set_geometry(0, 63, 3, 3);
		send_item(make_item(awds_pkg::OP_WRITE, 1, 0, 0, 0, 12345));
		send_item(make_item(awds_pkg::OP_WRITE, 0, 0, 5, 2, -1));
		send_item(make_item(awds_pkg::OP_WRITE, 0, 31, 7, 7, 32767));
		send_item(make_item(awds_pkg::OP_WRITE, 0, 31, 4, 4, -32768));
		query_pixel(1, 0, 1'b0);
		query_pixel(31, 31, 1'b0);
	endtask

	task automatic test_random_traffic();
		int ph;
		int goal;
		int phase_end;
		int anc_c;
		int anc_r;
		int hc;
		int hr;
		int roll;
		ph   = 0;
		goal = counted_items + RANDOM_ITEMS;
		while (counted_items < goal) begin
			case (ph % 10)
				0: set_geometry(32, 32, 1, 1);
				1: set_geometry(3, 2, 2, 2);
				2: set_geometry(1, 1, 0, 0);
				3: set_geometry(5, 4, 3, 1);
				4: set_geometry(0, 7, 1, 3);
				5: set_geometry(63, 2, 2, 0);
				6: set_geometry(8, 8, 1, 1);
				7: set_geometry(4, 63, 0, 2);
				8: set_geometry(2, 5, 3, 3);
				default: set_geometry(32, 32, 2, 2);
			endcase
			send_idle = (ph % 3 != 1);
			recv_idle = (ph % 3 != 2);
			// keep most traffic near one spot, often an image corner
			case ($urandom_range(0, 2))
				0: anc_c = 0;
				1: anc_c = img_w - 1;
				default: anc_c = int'($urandom_range(0, img_w - 1));
			endcase
			case ($urandom_range(0, 2))
				0: anc_r = 0;
				1: anc_r = img_h - 1;
				default: anc_r = int'($urandom_range(0, img_h - 1));
			endcase
			phase_end = counted_items + PHASE_ITEMS;
			while (counted_items < phase_end && counted_items < goal) begin
				roll = int'($urandom_range(0, 99));
				hc   = edge_clamp(anc_c + int'($urandom_range(0, 4)) - 2, img_w);
				hr   = edge_clamp(anc_r + int'($urandom_range(0, 4)) - 2, img_h);
				if (roll < 50)
					query_pixel(hc, hr, 1'b0);
				else if (roll < 60)
					query_pixel(int'($urandom_range(0, 31)), int'($urandom_range(0, 31)), 1'b0);
				else if (roll < 85)
					send_item(make_item(awds_pkg::OP_WRITE, hc, hr,
						int'($urandom_range(0, 2 * win_hw)),
						int'($urandom_range(0, 2 * win_hh)), int'($urandom)));
				else if (roll < 97)
					send_item(make_item(awds_pkg::OP_WRITE, int'($urandom_range(0, 31)),
						int'($urandom_range(0, 31)), int'($urandom_range(0, 7)),
						int'($urandom_range(0, 7)), int'($urandom)));
				else
					hold_for_results();
			end
			ph++;
		end
	endtask

	initial begin
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		in_data   = '0;
		psel      = 1'b0;
		penable   = 1'b0;
		pwrite    = 1'b0;
		paddr     = '0;
		pwdata    = '0;
		send_idle = 1'b1;
		recv_idle = 1'b1;
		fails     = 0;
		counted_items = 0;
		cfg_regs  = '{awds_pkg::IMG_WIDTH_RST, awds_pkg::IMG_HEIGHT_RST,
			awds_pkg::HALF_W_RST, awds_pkg::HALF_H_RST};
		update_geometry();
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_window();
		test_range_limits();
		test_random_traffic();

		wait_drained();
		if (fails == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
